// ===== rtl/acal_pkg.sv =====
// shared types and constants for the sensor auto-calibration block
// used by every module of the block; no dependencies
package acal_pkg;

  localparam int MAX_CHANNELS    = 6;
  localparam int FIELD_BITS      = 10;
  localparam int MAX_SAMPLE_BITS = 16;
  localparam int PERCENT_BITS    = 7;
  localparam int INDEX_BITS      = 3;
  localparam int SHIFT_BITS      = 3;

  localparam int CHANNELS_DEF    = 6;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int MIN_RESET  = 200;
  localparam int FULL_SCALE = 100;

  // top quotient bit of the divide (quotient is at most 100)
  localparam logic [SHIFT_BITS-1:0] DIV_FIRST = SHIFT_BITS'(PERCENT_BITS - 1);
  localparam logic [SHIFT_BITS-1:0] DIV_LAST  = '0;

  typedef struct packed {
    logic [FIELD_BITS-1:0] sample_0;
    logic [FIELD_BITS-1:0] sample_1;
    logic [FIELD_BITS-1:0] sample_2;
    logic [FIELD_BITS-1:0] sample_3;
    logic [FIELD_BITS-1:0] sample_4;
    logic [FIELD_BITS-1:0] sample_5;
  } in_item_t;

  typedef struct packed {
    logic [PERCENT_BITS-1:0] percent_0;
    logic [PERCENT_BITS-1:0] percent_1;
    logic [PERCENT_BITS-1:0] percent_2;
    logic [PERCENT_BITS-1:0] percent_3;
    logic [PERCENT_BITS-1:0] percent_4;
    logic [PERCENT_BITS-1:0] percent_5;
    logic [INDEX_BITS-1:0]   winner_index;
    logic [PERCENT_BITS-1:0] winner_percent;
  } out_item_t;

  // sequencer strobes shared by all lanes
  typedef struct packed {
    logic                  load;
    logic                  update;
    logic                  mult;
    logic                  div;
    logic [SHIFT_BITS-1:0] div_shift;
  } lane_ctl_t;

endpackage

// ===== rtl/acal_lane.sv =====
// one channel lane: running min/max bounds, scale by 100, 7-step restoring divide
// depends on acal_pkg
module acal_lane #(
  parameter int SAMPLE_BITS = acal_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  acal_pkg::lane_ctl_t                 ctl,
  input  logic [acal_pkg::FIELD_BITS-1:0]     sample,
  output logic [acal_pkg::PERCENT_BITS-1:0]   level
);

  localparam int PROD_BITS = SAMPLE_BITS + acal_pkg::PERCENT_BITS;

  logic [acal_pkg::MAX_SAMPLE_BITS-1:0] sample_wide;
  logic [SAMPLE_BITS-1:0]               x_in;
  logic [SAMPLE_BITS-1:0]               x;
  logic [SAMPLE_BITS-1:0]               seen_max;
  logic [SAMPLE_BITS-1:0]               seen_min;
  logic [SAMPLE_BITS-1:0]               span;
  logic [SAMPLE_BITS-1:0]               diff;
  logic [PROD_BITS-1:0]                 product;
  logic [PROD_BITS-1:0]                 rem;
  logic [PROD_BITS-1:0]                 trial;
  logic [acal_pkg::PERCENT_BITS-1:0]    quot;
  logic                                 flat;

  // sample taken modulo 2^SAMPLE_BITS
  assign sample_wide = acal_pkg::MAX_SAMPLE_BITS'(sample);
  assign x_in        = sample_wide[SAMPLE_BITS-1:0];

  // bounds already enclose x here
  assign diff    = x - seen_min;
  assign product = PROD_BITS'(diff) * PROD_BITS'(acal_pkg::FULL_SCALE);
  assign trial   = PROD_BITS'(span) << ctl.div_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_max <= '0;
      seen_min <= SAMPLE_BITS'(acal_pkg::MIN_RESET);
    end else if (ctl.update) begin
      if (x > seen_max) begin
        seen_max <= x;
      end
      if (x < seen_min) begin
        seen_min <= x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= x_in;
    end
    if (ctl.mult) begin
      rem  <= product;
      span <= seen_max - seen_min;
      flat <= (seen_max <= seen_min);
      quot <= '0;
    end else if (ctl.div) begin
      if (rem >= trial) begin
        rem             <= rem - trial;
        quot[ctl.div_shift] <= 1'b1;
      end
    end
  end

  // equal bounds give zero
  assign level = flat ? '0 : quot;

endmodule

// ===== rtl/acal_merge.sv =====
// merge stage: largest percentage over the lanes and the highest channel holding it
// depends on acal_pkg
module acal_merge #(
  parameter int CHANNELS = acal_pkg::CHANNELS_DEF
) (
  input  logic [acal_pkg::PERCENT_BITS-1:0] levels [acal_pkg::MAX_CHANNELS],
  output logic [acal_pkg::INDEX_BITS-1:0]   winner_index,
  output logic [acal_pkg::PERCENT_BITS-1:0] winner_percent
);

  always_comb begin
    winner_percent = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (levels[c] > winner_percent) begin
        winner_percent = levels[c];
      end
    end
    // ties go to the highest channel; all zero lands on the last channel
    winner_index = acal_pkg::INDEX_BITS'(CHANNELS - 1);
    for (int c = 0; c < CHANNELS; c++) begin
      if (levels[c] == winner_percent) begin
        winner_index = acal_pkg::INDEX_BITS'(c);
      end
    end
  end

endmodule

// ===== rtl/sensor_autocal_percent_argmax_top.sv =====
// top level of the sensor auto-calibration block: sequencer, lanes, merge, output register
// depends on acal_pkg, acal_lane and acal_merge
//
// usage
//   sample channel: one item carries one sample per channel; taken at a rising edge
//   with sample_valid high and sample_stall low. sample_stall is high during reset and
//   while an item is being worked on, so the block holds one item at a time.
//   result channel: one item per sample item, with a percentage per channel plus
//   the winning channel and its percentage; taken when result_valid is high and
//   result_stall is low.
//   the sample item passes through a bound update, a multiply by 100, 7 divide steps,
//   and a merge and load into the output register, in that order.
//   a new item is taken only once the last result is loaded; each lane runs the 7-step
//   restoring divider on its own channel, and all lanes run side by side.
//   the output register holds a finished result while the next item is taken;
//   if the receiver stalls, the following result waits in the merge step until
//   the register frees up, and the sample side stays stalled meanwhile.
//   reset: synchronous, active high; running max clears to 0 and running min to
//   200 in every channel, the sequencer returns to idle and the output empties.
module sensor_autocal_percent_argmax_top #(
  parameter int CHANNELS    = acal_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = acal_pkg::SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  acal_pkg::in_item_t  sample_item,
  output logic                result_valid,
  input  logic                result_stall,
  output acal_pkg::out_item_t result_item
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UPD  = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                            state;
  state_t                            state_next;
  logic [acal_pkg::SHIFT_BITS-1:0]   div_shift;
  acal_pkg::lane_ctl_t               ctl;
  logic                              accept;
  logic                              load_out;

  logic [acal_pkg::FIELD_BITS-1:0]   samples [acal_pkg::MAX_CHANNELS];
  logic [acal_pkg::PERCENT_BITS-1:0] levels  [acal_pkg::MAX_CHANNELS];
  logic [acal_pkg::INDEX_BITS-1:0]   winner_index;
  logic [acal_pkg::PERCENT_BITS-1:0] winner_percent;

  // item fields to lane order
  assign samples[0] = sample_item.sample_0;
  assign samples[1] = sample_item.sample_1;
  assign samples[2] = sample_item.sample_2;
  assign samples[3] = sample_item.sample_3;
  assign samples[4] = sample_item.sample_4;
  assign samples[5] = sample_item.sample_5;

  // handshakes; nothing is taken while reset is high
  assign sample_stall = rst || (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign load_out     = (state == S_DONE) && (!result_valid || !result_stall);

  // strobes for the lanes
  assign ctl.load      = accept;
  assign ctl.update    = (state == S_UPD);
  assign ctl.mult      = (state == S_MUL);
  assign ctl.div       = (state == S_DIV);
  assign ctl.div_shift = div_shift;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_UPD;
        end
      end
      S_UPD:  state_next = S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV: begin
        if (div_shift == acal_pkg::DIV_LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // divide step counter, top quotient bit first
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      div_shift <= acal_pkg::DIV_FIRST;
    end else if (state == S_DIV && div_shift != acal_pkg::DIV_LAST) begin
      div_shift <= div_shift - acal_pkg::SHIFT_BITS'(1);
    end
  end

  // one lane per channel in use; unused channels read as zero
  for (genvar c = 0; c < acal_pkg::MAX_CHANNELS; c++) begin : g_lane
    if (c < CHANNELS) begin : g_used
      acal_lane #(
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_lane (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .sample (samples[c]),
        .level  (levels[c])
      );
    end else begin : g_unused
      assign levels[c] = '0;
    end
  end

  acal_merge #(
    .CHANNELS(CHANNELS)
  ) u_merge (
    .levels         (levels),
    .winner_index   (winner_index),
    .winner_percent (winner_percent)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result_item.percent_0      <= levels[0];
      result_item.percent_1      <= levels[1];
      result_item.percent_2      <= levels[2];
      result_item.percent_3      <= levels[3];
      result_item.percent_4      <= levels[4];
      result_item.percent_5      <= levels[5];
      result_item.winner_index   <= winner_index;
      result_item.winner_percent <= winner_percent;
    end
  end

endmodule

// ===== verif/tb_sensor_autocal_percent_argmax_top.sv =====
// testbench for sensor_autocal_percent_argmax_top: running min/max scaling per channel plus argmax
// depends on acal_pkg and the top level; a tracker class predicts each result and checks it in order
module tb_sensor_autocal_percent_argmax_top;

  localparam int NUM_CH       = acal_pkg::CHANNELS_DEF;
  localparam int SBITS        = acal_pkg::SAMPLE_BITS_DEF;
  localparam int OUT_FIELDS   = 8;
  localparam int RANDOM_SETS  = 1950;
  localparam int CALM_FIRST   = 800;
  localparam int CALM_LAST    = 1100;
  localparam int DRAIN_CYCLES = 20;
  localparam int TOP          = (1 << acal_pkg::FIELD_BITS) - 1;

  // tracks running bounds per channel and holds the results still owed by the block
  class autocal_tracker;
    int run_max [acal_pkg::MAX_CHANNELS];
    int run_min [acal_pkg::MAX_CHANNELS];
    acal_pkg::out_item_t owed_levels [$];
    int errors;

    function new();
      int c;
      for (c = 0; c < acal_pkg::MAX_CHANNELS; c++) begin
        run_max[c] = 0;
        run_min[c] = acal_pkg::MIN_RESET % (1 << SBITS);
      end
      errors = 0;
    endfunction

    // update bounds with one accepted set and queue the result it must produce
    function void note_sample(acal_pkg::in_item_t it);
      int raw [acal_pkg::MAX_CHANNELS];
      int lvl [acal_pkg::MAX_CHANNELS];
      int best, best_at, x, c;
      acal_pkg::out_item_t want;
      raw = '{int'(it.sample_0), int'(it.sample_1), int'(it.sample_2),
              int'(it.sample_3), int'(it.sample_4), int'(it.sample_5)};
      best = 0;
      best_at = NUM_CH - 1;
      for (c = 0; c < acal_pkg::MAX_CHANNELS; c++) begin
        lvl[c] = 0;
        if (c < NUM_CH) begin
          x = raw[c] % (1 << SBITS);
          if (x > run_max[c]) run_max[c] = x;
          if (x < run_min[c]) run_min[c] = x;
          // equal bounds give zero instead of a divide by zero
          if (run_max[c] > run_min[c] && x >= run_min[c])
            lvl[c] = (x - run_min[c]) * acal_pkg::FULL_SCALE / (run_max[c] - run_min[c]);
          if (lvl[c] > best) best = lvl[c];
        end
      end
      // ties go to the highest channel; all zero leaves the last channel
      for (c = 0; c < NUM_CH; c++)
        if (lvl[c] == best) best_at = c;
      want.percent_0      = acal_pkg::PERCENT_BITS'(lvl[0]);
      want.percent_1      = acal_pkg::PERCENT_BITS'(lvl[1]);
      want.percent_2      = acal_pkg::PERCENT_BITS'(lvl[2]);
      want.percent_3      = acal_pkg::PERCENT_BITS'(lvl[3]);
      want.percent_4      = acal_pkg::PERCENT_BITS'(lvl[4]);
      want.percent_5      = acal_pkg::PERCENT_BITS'(lvl[5]);
      want.winner_index   = acal_pkg::INDEX_BITS'(best_at);
      want.winner_percent = acal_pkg::PERCENT_BITS'(best);
      owed_levels.push_back(want);
    endfunction

    function void flatten(acal_pkg::out_item_t r, output logic [7:0] v [OUT_FIELDS]);
      v = '{8'(r.percent_0), 8'(r.percent_1), 8'(r.percent_2), 8'(r.percent_3),
            8'(r.percent_4), 8'(r.percent_5), 8'(r.winner_index), 8'(r.winner_percent)};
    endfunction

    function void check_result(acal_pkg::out_item_t got);
      string names [OUT_FIELDS] = '{"percent_0", "percent_1", "percent_2", "percent_3",
                                   "percent_4", "percent_5", "winner_index", "winner_percent"};
      logic [7:0] w [OUT_FIELDS];
      logic [7:0] g [OUT_FIELDS];
      int f;
      if (owed_levels.size() == 0) begin
        $error("result with no sample set pending: %p", got);
        errors++;
        return;
      end
      flatten(owed_levels.pop_front(), w);
      flatten(got, g);
      for (f = 0; f < OUT_FIELDS; f++)
        if (g[f] !== w[f]) begin
          $error("%s: expected %0d, actual %0d", names[f], w[f], g[f]);
          errors++;
        end
    endfunction

    function int pending();
      return owed_levels.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                sample_valid = 1'b0;
  logic                sample_stall;
  acal_pkg::in_item_t  sample_item = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  acal_pkg::out_item_t result_item;

  autocal_tracker tracker = new();
  bit calm = 1'b0;     // no idling on either side while set
  int stall_left = 0;  // cycles left in the current receiver stall

  sensor_autocal_percent_argmax_top uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_item  (sample_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check taken items, then pick the stall for the next cycle
  // stalls come in runs whose length is drawn at random so they land on every phase of the divider
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall)
        tracker.check_result(result_item);
      if (stall_left > 0)
        stall_left--;
      else if (!calm && $urandom_range(99) < 4)
        stall_left = $urandom_range(1, 14);
      result_stall <= (stall_left > 0);
    end
  end

  function automatic acal_pkg::in_item_t make_set(int a, int b, int c, int d, int e, int f);
    return '{acal_pkg::FIELD_BITS'(a), acal_pkg::FIELD_BITS'(b), acal_pkg::FIELD_BITS'(c),
             acal_pkg::FIELD_BITS'(d), acal_pkg::FIELD_BITS'(e), acal_pkg::FIELD_BITS'(f)};
  endfunction

  // mostly full-range samples, some pinned to the ends of the range, some shared for ties
  function automatic acal_pkg::in_item_t random_sample_set();
    int v [acal_pkg::MAX_CHANNELS];
    int shared, mode, c;
    mode = $urandom_range(99);
    shared = $urandom_range(TOP);
    for (c = 0; c < acal_pkg::MAX_CHANNELS; c++) begin
      if (mode < 65)
        v[c] = $urandom_range(TOP);
      else if (mode < 85)
        case ($urandom_range(4))
          0:       v[c] = 0;
          1:       v[c] = 1;
          2:       v[c] = TOP - 1;
          3:       v[c] = TOP;
          default: v[c] = $urandom_range(TOP);
        endcase
      else
        v[c] = $urandom_range(1) ? shared : int'($urandom_range(TOP));
    end
    return make_set(v[0], v[1], v[2], v[3], v[4], v[5]);
  endfunction

  // offer one item, with an optional gap first, and hold it until taken
  task automatic send_item(acal_pkg::in_item_t it);
    int gap;
    if (!calm && $urandom_range(99) < 35) begin
      sample_valid <= 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_item  <= it;
    do @(posedge clk); while (sample_stall);
    tracker.note_sample(it);
  endtask

  initial begin
    acal_pkg::in_item_t directed_sets [$];
    int c, n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // first set all zero: bounds meet at 0, every percentage 0, channel 5 wins
    directed_sets.push_back(make_set(0, 0, 0, 0, 0, 0));
    // full scale everywhere: six-way tie at 100
    directed_sets.push_back(make_set(TOP, TOP, TOP, TOP, TOP, TOP));
    directed_sets.push_back(make_set(0, 0, 0, 0, 0, 0));
    // each channel alone at the top
    for (c = 0; c < acal_pkg::MAX_CHANNELS; c++)
      directed_sets.push_back(make_set(c == 0 ? TOP : 0, c == 1 ? TOP : 0, c == 2 ? TOP : 0,
                                       c == 3 ? TOP : 0, c == 4 ? TOP : 0, c == 5 ? TOP : 0));
    // tie between two inner channels
    directed_sets.push_back(make_set(0, TOP, 0, TOP, 0, 0));
    directed_sets.push_back(make_set(511, 511, 511, 511, 511, 511));
    directed_sets.push_back(make_set(0, 200, 400, 600, 800, 1000));
    directed_sets.push_back(make_set(1000, 800, 600, 400, 200, 0));
    // one lsb above the floor truncates to 0 everywhere
    directed_sets.push_back(make_set(1, 1, 1, 1, 1, 1));
    directed_sets.push_back(make_set(TOP - 1, TOP - 1, TOP - 1, TOP - 1, TOP - 1, TOP - 1));
    directed_sets.push_back(make_set('h155, 'h2aa, 'h155, 'h2aa, 'h155, 'h2aa));
    directed_sets.push_back(make_set('h2aa, 'h155, 'h2aa, 'h155, 'h2aa, 'h155));
    directed_sets.push_back(make_set(TOP, 0, 0, 0, 0, 1));
    foreach (directed_sets[i])
      send_item(directed_sets[i]);

    for (n = 0; n < RANDOM_SETS; n++) begin
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      send_item(random_sample_set());
    end
    calm = 1'b0;
    sample_valid <= 1'b0;

    // drain, then give a stray result time to show up
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
